FILE: rtl/core/ihist_pkg.sv
`timescale 1ns / 1ps

package ihist_pkg;

  localparam int unsigned TICK_W        = 32;
  localparam int unsigned CPU_MHZ_W     = 12;
  localparam int unsigned VEC_W         = 12;
  localparam int unsigned SEL_W         = 5;
  localparam int unsigned BUCKET_W      = 5;
  localparam int unsigned TICKS_PER_MHZ = 100;
  // cpu_mhz * 100 fits in 12 + 7 bits
  localparam int unsigned QUANTUM_W     = CPU_MHZ_W + 7;

  typedef enum logic [1:0] {
    CMD_MARK     = 2'd0,
    CMD_RECORD   = 2'd1,
    CMD_READ     = 2'd2,
    CMD_IDLE_ADD = 2'd3
  } cmd_e;

  // One classified request handed from front to back.
  typedef struct packed {
    cmd_e                cmd;
    logic [TICK_W-1:0]   diff;       // elapsed ticks (record only)
    logic [VEC_W-1:0]    vec;        // clamped vector
    logic [SEL_W-1:0]    sel;        // clamped bucket select
    logic [TICK_W-1:0]   svc_total;  // interrupt total after this request
    logic [TICK_W-1:0]   idle_total; // idle total after this request
  } job_t;

endpackage

FILE: rtl/core/ihist_front.sv
`timescale 1ns / 1ps

module ihist_front #(
  parameter int unsigned NUM_VECTORS = 1024,
  parameter int unsigned NUM_BUCKETS = 20
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      command_i,
  input  logic [ihist_pkg::TICK_W-1:0]    ticks_i,
  input  logic [ihist_pkg::VEC_W-1:0]     vector_i,
  input  logic                            no_process_i,
  input  logic [ihist_pkg::SEL_W-1:0]     bucket_select_i,
  input  logic                            clearing_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output ihist_pkg::job_t                 q_job_o
);
  import ihist_pkg::*;

  logic [TICK_W-1:0] stamp_q, stamp_d;
  logic [TICK_W-1:0] svc_q, svc_d;
  logic [TICK_W-1:0] idle_q, idle_d;
  logic [TICK_W-1:0] diff;
  logic              accept;
  cmd_e              cmd;

  assign cmd        = cmd_e'(command_i);
  assign in_stall_o = q_full_i | clearing_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign diff       = ticks_i - stamp_q;

  always_comb begin
    stamp_d = stamp_q;
    svc_d   = svc_q;
    idle_d  = idle_q;
    unique case (cmd)
      CMD_MARK: begin
        stamp_d = ticks_i;
      end
      CMD_RECORD: begin
        stamp_d = ticks_i;
        svc_d   = svc_q + diff;
        if (no_process_i && (idle_q > diff)) begin
          idle_d = idle_q - diff;
        end
      end
      CMD_IDLE_ADD: begin
        idle_d = idle_q + ticks_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_q <= '0;
      svc_q   <= '0;
      idle_q  <= '0;
    end else if (accept) begin
      stamp_q <= stamp_d;
      svc_q   <= svc_d;
      idle_q  <= idle_d;
    end
  end

  always_comb begin
    q_job_o.cmd        = cmd;
    q_job_o.diff       = diff;
    q_job_o.vec        = (vector_i >= NUM_VECTORS) ? VEC_W'(NUM_VECTORS - 1) : vector_i;
    q_job_o.sel        = (bucket_select_i >= NUM_BUCKETS) ? SEL_W'(NUM_BUCKETS - 1)
                                                          : bucket_select_i;
    q_job_o.svc_total  = svc_d;
    q_job_o.idle_total = idle_d;
  end

  assign q_push_o = accept;

endmodule

FILE: rtl/core/ihist_fifo.sv
`timescale 1ns / 1ps

module ihist_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ihist_pkg::job_t job_i,
  output logic            full_o,
  input  logic            pop_i,
  output ihist_pkg::job_t job_o,
  output logic            empty_o
);
  import ihist_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  job_t            entry_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign job_o   = entry_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/ihist_back.sv
`timescale 1ns / 1ps

module ihist_back #(
  parameter int unsigned NUM_VECTORS = 1024,
  parameter int unsigned NUM_BUCKETS = 20
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [ihist_pkg::CPU_MHZ_W-1:0]  cpu_mhz_i,
  input  ihist_pkg::job_t                  q_job_i,
  input  logic                             q_empty_i,
  output logic                             q_pop_o,
  output logic                             clearing_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [ihist_pkg::TICK_W-1:0]     counter_value_o,
  output logic [ihist_pkg::BUCKET_W-1:0]   bucket_o,
  output logic                             recorded_o,
  output logic [ihist_pkg::TICK_W-1:0]     interrupt_total_o,
  output logic [ihist_pkg::TICK_W-1:0]     idle_total_o
);
  import ihist_pkg::*;

  localparam int unsigned Depth = NUM_VECTORS * NUM_BUCKETS;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned BW    = $clog2(NUM_BUCKETS);

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_DIVIDE = 7'b0000100,
    ST_ADDR   = 7'b0001000,
    ST_READ   = 7'b0010000,
    ST_UPDATE = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_e;

  state_e                state_q, state_d;
  job_t                  job_q;
  logic [TICK_W-1:0]     rem_q;
  logic [QUANTUM_W-1:0]  quantum_q;
  logic [BW-1:0]         quot_q;
  logic [AW-1:0]         addr_q;
  logic [AW-1:0]         clr_q;
  logic [TICK_W-1:0]     rdata_q;
  logic [TICK_W-1:0]     res_value_q;
  logic                  res_rec_q;

  logic [TICK_W-1:0]     mem [Depth];
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [TICK_W-1:0]     mem_wdata;

  logic                  div_more;
  logic                  out_free;
  logic                  is_record;
  logic [TICK_W-1:0]     bumped;

  logic                  out_valid_q;
  logic [TICK_W-1:0]     out_value_q;
  logic [BW-1:0]         out_bucket_q;
  logic                  out_rec_q;
  logic [TICK_W-1:0]     out_svc_q, out_idle_q;

  assign is_record = (job_q.cmd == CMD_RECORD);
  assign div_more  = (rem_q >= TICK_W'(quantum_q)) && (quot_q != BW'(NUM_BUCKETS - 1));
  assign out_free  = ~out_valid_q | ~out_stall_i;
  assign bumped    = rdata_q + 1'b1;
  assign q_pop_o   = (state_q == ST_IDLE) & ~q_empty_i;
  assign clearing_o = (state_q == ST_CLEAR);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (clr_q == AW'(Depth - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (!q_empty_i) begin
          if (q_job_i.cmd == CMD_RECORD && cpu_mhz_i != '0) begin
            state_d = ST_DIVIDE;
          end else if (q_job_i.cmd == CMD_READ) begin
            state_d = ST_ADDR;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_DIVIDE: if (!div_more) state_d = ST_ADDR;
      ST_ADDR:   state_d = ST_READ;
      ST_READ:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_FINISH;
      ST_FINISH: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = bumped;
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (state_q == ST_UPDATE && is_record) begin
      mem_we = 1'b1;
    end
  end

  // histogram store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[addr_q];
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        job_q       <= q_job_i;
        rem_q       <= q_job_i.diff;
        quantum_q   <= QUANTUM_W'(cpu_mhz_i) * QUANTUM_W'(TICKS_PER_MHZ);
        quot_q      <= (q_job_i.cmd == CMD_READ) ? BW'(q_job_i.sel) : '0;
        res_value_q <= '0;
        res_rec_q   <= 1'b0;
      end
      ST_DIVIDE: begin
        if (div_more) begin
          rem_q  <= rem_q - TICK_W'(quantum_q);
          quot_q <= quot_q + 1'b1;
        end
      end
      ST_ADDR: begin
        addr_q <= AW'(AW'(job_q.vec) * AW'(NUM_BUCKETS)) + AW'(quot_q);
      end
      ST_UPDATE: begin
        res_value_q <= is_record ? bumped : rdata_q;
        res_rec_q   <= is_record;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FINISH && out_free) begin
      out_value_q  <= res_value_q;
      out_bucket_q <= res_rec_q ? quot_q : '0;
      out_rec_q    <= res_rec_q;
      out_svc_q    <= job_q.svc_total;
      out_idle_q   <= job_q.idle_total;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign counter_value_o   = out_value_q;
  assign bucket_o          = BUCKET_W'(out_bucket_q);
  assign recorded_o        = out_rec_q;
  assign interrupt_total_o = out_svc_q;
  assign idle_total_o      = out_idle_q;

endmodule

FILE: rtl/core/interrupt_service_time_histogram.sv
// Mark and idle-add go from idle to finish; read passes address, read and
// update first; record also divides (repeated subtraction of cpu_mhz*100,
// one step per cycle), or goes straight to finish if cpu_mhz is zero. The
// back end takes one request at a time; the front keeps accepting into a
// 2-entry queue meanwhile. Reset: async active low; then a clearing pass
// zeroes the NUM_VECTORS*NUM_BUCKETS (20480 default) entries, in_stall_o high.
`timescale 1ns / 1ps

module interrupt_service_time_histogram #(
  parameter int unsigned NUM_VECTORS = 1024,
  parameter int unsigned NUM_BUCKETS = 20
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config: cpu_mhz
  input  logic                             cfg_we_i,
  input  logic [ihist_pkg::CPU_MHZ_W-1:0]  cfg_wdata_i,
  // request channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       command_i,
  input  logic [ihist_pkg::TICK_W-1:0]     ticks_i,
  input  logic [ihist_pkg::VEC_W-1:0]      vector_i,
  input  logic                             no_process_i,
  input  logic [ihist_pkg::SEL_W-1:0]      bucket_select_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [ihist_pkg::TICK_W-1:0]     counter_value_o,
  output logic [ihist_pkg::BUCKET_W-1:0]   bucket_o,
  output logic                             recorded_o,
  output logic [ihist_pkg::TICK_W-1:0]     interrupt_total_o,
  output logic [ihist_pkg::TICK_W-1:0]     idle_total_o
);
  import ihist_pkg::*;

  // cpu_mhz register; zero disables histogram updates
  logic [CPU_MHZ_W-1:0] cpu_mhz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_mhz_q <= '0;
    end else if (cfg_we_i) begin
      cpu_mhz_q <= cfg_wdata_i;
    end
  end

  // front -> queue -> back
  job_t push_job, pop_job;
  logic push, pop, q_full, q_empty, clearing;

  // Front: owns timestamp and the two running totals, so every request
  // leaves with its final totals already computed. Clamps vector/select.
  ihist_front #(
    .NUM_VECTORS (NUM_VECTORS),
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .ticks_i         (ticks_i),
    .vector_i        (vector_i),
    .no_process_i    (no_process_i),
    .bucket_select_i (bucket_select_i),
    .clearing_i      (clearing),
    .q_full_i        (q_full),
    .q_push_o        (push),
    .q_job_o         (push_job)
  );

  // Short queue so the front keeps taking requests while the back divides.
  ihist_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .job_o   (pop_job),
    .empty_o (q_empty)
  );

  // Back: bucket search, histogram RMW, output register.
  ihist_back #(
    .NUM_VECTORS (NUM_VECTORS),
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cpu_mhz_i         (cpu_mhz_q),
    .q_job_i           (pop_job),
    .q_empty_i         (q_empty),
    .q_pop_o           (pop),
    .clearing_o        (clearing),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .counter_value_o   (counter_value_o),
    .bucket_o          (bucket_o),
    .recorded_o        (recorded_o),
    .interrupt_total_o (interrupt_total_o),
    .idle_total_o      (idle_total_o)
  );

endmodule

FILE: bench/interrupt_service_time_histogram_test.sv
`timescale 1ns / 1ps

module interrupt_service_time_histogram_test;

  import ihist_pkg::*;

  localparam int unsigned NUM_VECTORS = 1024;
  localparam int unsigned NUM_BUCKETS = 20;
  // Covers the clearing pass and ~475 requests several times over, even with
  // every gap and stall at its longest.
  localparam int unsigned CYCLE_LIMIT = 300000;
  // Margin for the longest request, a record, through the back end.
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned MAX_REPORTS = 50;

  // One request as the sender presents it.
  typedef struct packed {
    cmd_e                cmd;
    logic [TICK_W-1:0]   ticks;
    logic [VEC_W-1:0]    vec;
    logic                no_proc;
    logic [SEL_W-1:0]    sel;
  } hist_request_t;

  // One result as the block should return it.
  typedef struct packed {
    logic [TICK_W-1:0]   count;
    logic [BUCKET_W-1:0] bucket;
    logic                rec;
    logic [TICK_W-1:0]   svc;
    logic [TICK_W-1:0]   idle;
  } hist_result_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_we_i        = 1'b0;
  logic [CPU_MHZ_W-1:0] cfg_wdata_i     = '0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           command_i       = CMD_MARK;
  logic [TICK_W-1:0]    ticks_i         = '0;
  logic [VEC_W-1:0]     vector_i        = '0;
  logic                 no_process_i    = 1'b0;
  logic [SEL_W-1:0]     bucket_select_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i     = 1'b0;
  logic [TICK_W-1:0]    counter_value_o;
  logic [BUCKET_W-1:0]  bucket_o;
  logic                 recorded_o;
  logic [TICK_W-1:0]    interrupt_total_o;
  logic [TICK_W-1:0]    idle_total_o;

  interrupt_service_time_histogram #(
    .NUM_VECTORS (NUM_VECTORS),
    .NUM_BUCKETS (NUM_BUCKETS)
  ) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .ticks_i           (ticks_i),
    .vector_i          (vector_i),
    .no_process_i      (no_process_i),
    .bucket_select_i   (bucket_select_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .counter_value_o   (counter_value_o),
    .bucket_o          (bucket_o),
    .recorded_o        (recorded_o),
    .interrupt_total_o (interrupt_total_o),
    .idle_total_o      (idle_total_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow state of the histogram block. Updated at the edge a request is
  // accepted; cpu_mhz only changes while nothing is in flight.
  // ---------------------------------------------------------------------------
  logic [CPU_MHZ_W-1:0] mhz_setting = '0;
  logic [TICK_W-1:0]    mark_stamp  = '0;
  logic [TICK_W-1:0]    service_sum = '0;
  logic [TICK_W-1:0]    idle_sum    = '0;
  bit   [TICK_W-1:0]    bucket_counts [NUM_VECTORS*NUM_BUCKETS];

  hist_request_t request_queue[$];     // requests not yet presented
  hist_result_t  expected_results[$];  // accepted, result still owed

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned gap_left       = 0;
  int unsigned stall_left     = 0;
  bit          gaps_on        = 1'b1;  // random idling on both sides

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("[%0t] MISMATCH %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
  endtask

  // Service time histogram step: timestamps, totals, bucket choice and count.
  function automatic hist_result_t predict_service_step(input hist_request_t rq);
    hist_result_t r;
    logic [TICK_W-1:0] elapsed;
    logic [TICK_W-1:0] quantum;
    logic [TICK_W-1:0] quot;
    int unsigned vec;
    int unsigned sel;
    int unsigned bkt;
    r = '0;
    // out-of-range vector and bucket select saturate to the last entry
    vec = (rq.vec >= NUM_VECTORS) ? NUM_VECTORS - 1 : rq.vec;
    sel = (rq.sel >= NUM_BUCKETS) ? NUM_BUCKETS - 1 : rq.sel;
    case (rq.cmd)
      CMD_MARK: mark_stamp = rq.ticks;
      CMD_RECORD: begin
        elapsed = rq.ticks - mark_stamp;  // wraps mod 2^32
        mark_stamp = rq.ticks;
        service_sum += elapsed;
        // idle is only reduced when strictly larger than the service time
        if (rq.no_proc && idle_sum > elapsed)
          idle_sum -= elapsed;
        if (mhz_setting != '0) begin
          quantum = mhz_setting * TICKS_PER_MHZ;
          quot = elapsed / quantum;
          bkt = (quot >= NUM_BUCKETS) ? NUM_BUCKETS - 1 : quot;
          bucket_counts[vec*NUM_BUCKETS + bkt] += 1;
          r.count  = bucket_counts[vec*NUM_BUCKETS + bkt];
          r.bucket = BUCKET_W'(bkt);
          r.rec    = 1'b1;
        end
      end
      CMD_READ: r.count = bucket_counts[vec*NUM_BUCKETS + sel];
      default: idle_sum += rq.ticks;
    endcase
    r.svc  = service_sum;
    r.idle = idle_sum;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: presents queued requests, holds a stalled one steady,
  // and inserts random idle bursts when enabled.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : req_driver
    hist_request_t nxt;
    logic          nxt_valid;
    if (rst_ni) begin
      nxt_valid = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(predict_service_step(
          '{cmd_e'(command_i), ticks_i, vector_i, no_process_i, bucket_select_i}));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_queue.size() != 0) begin
          if (gaps_on && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(1, 6) - 1;
          end else begin
            nxt = request_queue.pop_front();
            nxt_valid = 1'b1;
            command_i       <= nxt.cmd;
            ticks_i         <= nxt.ticks;
            vector_i        <= nxt.vec;
            no_process_i    <= nxt.no_proc;
            bucket_select_i <= nxt.sel;
          end
        end
      end
      in_valid_i <= nxt_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks each accepted result against the oldest
  // expectation, and stalls the block in random bursts.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_monitor
    hist_result_t want;
    logic         nxt_stall;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", counter_value_o, 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (counter_value_o !== want.count)
            report_mismatch("counter_value", counter_value_o, want.count);
          if (bucket_o !== want.bucket)
            report_mismatch("bucket", 32'(bucket_o), 32'(want.bucket));
          if (recorded_o !== want.rec)
            report_mismatch("recorded", 32'(recorded_o), 32'(want.rec));
          if (interrupt_total_o !== want.svc)
            report_mismatch("interrupt_total", interrupt_total_o, want.svc);
          if (idle_total_o !== want.idle)
            report_mismatch("idle_total", idle_total_o, want.idle);
        end
      end
      nxt_stall = 1'b0;
      if (stall_left > 0) begin
        stall_left--;
        nxt_stall = 1'b1;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        nxt_stall = 1'b1;
      end
      out_stall_i <= nxt_stall;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_request(input cmd_e cmd, input logic [TICK_W-1:0] t,
                              input logic [VEC_W-1:0] v, input logic np,
                              input logic [SEL_W-1:0] s);
    request_queue.push_back('{cmd, t, v, np, s});
  endtask

  // Sampled at the falling edge so nothing races the driver or the monitor.
  task automatic wait_drained();
    @(negedge clk_i);
    while (request_queue.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(negedge clk_i);
  endtask

  // Only called with the block idle.
  task automatic write_cpu_mhz(input logic [CPU_MHZ_W-1:0] mhz);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mhz;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    mhz_setting = mhz;
    @(negedge clk_i);
  endtask

  // Mostly a handful of low vectors so counters climb past 1; also the last
  // vector, clamped ones and anything at all.
  function automatic logic [VEC_W-1:0] pick_vector();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60) return VEC_W'($urandom_range(0, 7));
    if (p < 75) return VEC_W'(NUM_VECTORS - 1);
    if (p < 85) return VEC_W'($urandom_range(NUM_VECTORS, (1 << VEC_W) - 1));
    return VEC_W'($urandom);
  endfunction

  // Service time spread over all buckets plus a little past the last one.
  function automatic logic [TICK_W-1:0] service_span();
    if (mhz_setting == '0 || $urandom_range(0, 7) == 0)
      return $urandom;
    return $urandom_range(0, mhz_setting * TICKS_PER_MHZ * (NUM_BUCKETS + 2));
  endfunction

  // Last timestamp queued for a mark or record, so lone records get sane spans.
  function automatic logic [TICK_W-1:0] mark_stamp_hint();
    for (int i = request_queue.size() - 1; i >= 0; i--)
      if (request_queue[i].cmd == CMD_MARK || request_queue[i].cmd == CMD_RECORD)
        return request_queue[i].ticks;
    return mark_stamp;
  endfunction

  task automatic queue_random_traffic(input int unsigned n_items);
    int unsigned made;
    int unsigned p;
    logic [TICK_W-1:0] t;
    made = 0;
    while (made < n_items) begin
      p = $urandom_range(0, 99);
      if (p < 40) begin
        // well-formed entry/exit pair
        t = $urandom;
        push_request(CMD_MARK, t, pick_vector(), 1'($urandom_range(0, 1)),
                     SEL_W'($urandom_range(0, 31)));
        push_request(CMD_RECORD, t + service_span(), pick_vector(),
                     1'($urandom_range(0, 1)), SEL_W'($urandom_range(0, 31)));
        made += 2;
      end else begin
        if (p < 52)
          // back-to-back record: elapsed since the previous one
          push_request(CMD_RECORD, mark_stamp_hint() + service_span(), pick_vector(),
                       1'($urandom_range(0, 1)), SEL_W'($urandom_range(0, 31)));
        else if (p < 72)
          push_request(CMD_READ, $urandom, pick_vector(), 1'($urandom_range(0, 1)),
                       SEL_W'($urandom_range(0, 31)));
        else if (p < 86)
          push_request(CMD_IDLE_ADD,
                       ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000000),
                       pick_vector(), 1'($urandom_range(0, 1)),
                       SEL_W'($urandom_range(0, 31)));
        else
          push_request(cmd_e'($urandom_range(0, 3)), $urandom, VEC_W'($urandom),
                       1'($urandom_range(0, 1)), SEL_W'($urandom_range(0, 31)));
        made++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: one bucket per 100 ticks. The clearing pass holds the
    // requests off until the store is zeroed.
    write_cpu_mhz(CPU_MHZ_W'(1));
    push_request(CMD_READ, 32'd0, 12'd0, 1'b0, 5'd0);
    push_request(CMD_IDLE_ADD, 32'd300, 12'd0, 1'b0, 5'd0);
    push_request(CMD_MARK, 32'd1000, 12'd0, 1'b0, 5'd0);
    // idle equal to the service time: left alone
    push_request(CMD_RECORD, 32'd1300, 12'd0, 1'b1, 5'd0);
    // idle larger: deducted
    push_request(CMD_RECORD, 32'd1400, 12'd0, 1'b1, 5'd0);
    // a process was running: no deduction
    push_request(CMD_RECORD, 32'd1450, 12'd0, 1'b0, 5'd0);
    // timestamp wrap, vector clamp
    push_request(CMD_MARK, 32'hFFFF_FFF0, 12'd0, 1'b0, 5'd0);
    push_request(CMD_RECORD, 32'h0000_0010, 12'hFFF, 1'b1, 5'd0);
    // long service lands in the last bucket
    push_request(CMD_MARK, 32'd0, 12'd0, 1'b0, 5'd0);
    push_request(CMD_RECORD, 32'hFFFF_FFFF, 12'd1023, 1'b0, 5'd31);
    push_request(CMD_READ, 32'hFFFF_FFFF, 12'hFFF, 1'b1, 5'd31);
    push_request(CMD_READ, 32'd0, 12'd1023, 1'b0, 5'd19);
    push_request(CMD_READ, 32'd0, 12'd1023, 1'b0, 5'd20);
    push_request(CMD_READ, 32'd0, 12'd0, 1'b0, 5'd3);
    push_request(CMD_IDLE_ADD, 32'hFFFF_FFFF, 12'd0, 1'b0, 5'd0);
    // exactly the last bucket, then one tick over it
    push_request(CMD_MARK, 32'd0, 12'd1, 1'b0, 5'd0);
    push_request(CMD_RECORD, 32'd1999, 12'd1, 1'b0, 5'd0);
    push_request(CMD_RECORD, 32'd3999, 12'd1, 1'b0, 5'd0);
    push_request(CMD_READ, 32'd0, 12'd1, 1'b0, 5'd19);
    wait_drained();

    // histogram disabled: totals move, nothing recorded
    write_cpu_mhz('0);
    push_request(CMD_MARK, 32'd5, 12'd0, 1'b0, 5'd0);
    push_request(CMD_RECORD, 32'd10, 12'd0, 1'b1, 5'd0);
    push_request(CMD_READ, 32'd0, 12'd0, 1'b0, 5'd0);
    wait_drained();

    // widest bucket span
    write_cpu_mhz('1);
    push_request(CMD_MARK, 32'd0, 12'd2, 1'b0, 5'd0);
    push_request(CMD_RECORD, 32'd409499, 12'd2, 1'b0, 5'd0);
    push_request(CMD_RECORD, 32'hFFFF_FFFF, 12'd2, 1'b1, 5'd0);
    push_request(CMD_READ, 32'd0, 12'd2, 1'b0, 5'd0);
    wait_drained();

    // Random phases, each starting with the block fully drained.
    write_cpu_mhz(CPU_MHZ_W'($urandom_range(1, 20)));
    queue_random_traffic(100);
    wait_drained();

    write_cpu_mhz('0);
    queue_random_traffic(40);
    wait_drained();

    write_cpu_mhz('1);
    queue_random_traffic(60);
    wait_drained();

    write_cpu_mhz(CPU_MHZ_W'($urandom_range(1, 4095)));
    queue_random_traffic(100);
    wait_drained();

    // closing stretch at full rate on both sides
    gaps_on = 1'b0;
    write_cpu_mhz(CPU_MHZ_W'($urandom_range(1, 8)));
    queue_random_traffic(150);
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch("results never produced", expected_results.size(), 32'd0);

    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: interrupt_service_time_histogram.f
rtl/core/ihist_pkg.sv
rtl/core/ihist_front.sv
rtl/core/ihist_fifo.sv
rtl/core/ihist_back.sv
rtl/core/interrupt_service_time_histogram.sv
bench/interrupt_service_time_histogram_test.sv
